// ----- rtl/multi_width_crc_engine_assert.svh -----
// assertion macros shared by the rtl of the multi-width crc engine
// no dependencies; included by files that carry concurrent assertions
`ifndef MULTI_WIDTH_CRC_ENGINE_ASSERT_SVH
`define MULTI_WIDTH_CRC_ENGINE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MWCE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mwce assertion failed: same-cycle check");

// next-cycle implication, checked out of reset
`define MWCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mwce assertion failed: next-cycle check");

`endif

// ----- rtl/mwce_pkg.sv -----
// types, codes and the byte-wide crc step for the multi-width crc engine
// no dependencies; imported by multi_width_crc_engine
package mwce_pkg;

	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CrcW    = 32;

	// width select codes
	localparam logic [1:0] CMD_CRC8  = 2'd0;
	localparam logic [1:0] CMD_CRC16 = 2'd1;
	localparam logic [1:0] CMD_CRC32 = 2'd2;
	localparam logic [1:0] CMD_NONE  = 2'd3;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] REG_MODULE_READY = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_POLY_8       = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_POLY_16      = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_POLY_32      = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_SEED_8       = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_SEED_16      = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_SEED_32      = 3'd6;

	// reset values
	localparam logic [7:0]  POLY_8_RST  = 8'h1D;
	localparam logic [15:0] POLY_16_RST = 16'h1021;
	localparam logic [31:0] POLY_32_RST = 32'h04C11DB7;
	localparam logic [7:0]  SEED_8_RST  = 8'hFF;
	localparam logic [15:0] SEED_16_RST = 16'hFFFF;
	localparam logic [31:0] SEED_32_RST = 32'hFFFFFFFF;

	// final xor per width
	localparam logic [7:0]  XOROUT_8  = 8'hFF;
	localparam logic [15:0] XOROUT_16 = 16'h0000;
	localparam logic [31:0] XOROUT_32 = 32'hFFFFFFFF;

	localparam logic       STATUS_OK        = 1'b0;
	localparam logic       STATUS_NOT_READY = 1'b1;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  data_byte;
		logic        first_byte;
		logic        last_byte;
		logic        use_initial;
		logic [31:0] start_value;
	} byte_item_t;

	typedef struct packed {
		logic [31:0] crc_value;
		logic        status;
	} res_item_t;

	// one byte, msb first, on a register left-aligned to bit 31
	function automatic logic [CrcW-1:0] crc_byte_step(
		input logic [CrcW-1:0] crc_in,
		input logic [7:0]      data,
		input logic [CrcW-1:0] poly
	);
		logic [CrcW-1:0] crc;
		crc = crc_in ^ {data, {(CrcW-8){1'b0}}};
		for (int b = 0; b < 8; b++) begin
			if (crc[CrcW-1]) begin
				crc = {crc[CrcW-2:0], 1'b0} ^ poly;
			end else begin
				crc = {crc[CrcW-2:0], 1'b0};
			end
		end
		return crc;
	endfunction

endpackage

// ----- rtl/multi_width_crc_engine.sv -----
// multi-width crc engine top level: input stage, crc update and result register
// depends on mwce_pkg and multi_width_crc_engine_assert.svh
//
// usage:
//   byte channel (byte_valid / byte_stall / byte_item) carries one message byte per
//   item with its width select (crc-8, crc-16 or crc-32) and first/last marks.
//   result channel (res_valid / res_stall / res_item) carries one crc result for
//   each item marked last whose width select is valid.
//   configuration is written through cfg_we / cfg_index / cfg_wdata while idle.
// path: an accepted item is registered into the input stage and updated there;
//   its result is then registered onto res_valid when that stage can advance.
// throughput: one item per cycle while byte_stall stays low, set by the eight-bit
//   xor network that closes the loop through the running crc register.
// reset: all configuration registers take their standard values, module_ready
//   clears (every result then reports not initialised), running crc clears and
//   both stages empty.
// stall: a held result keeps its register; the input stage keeps accepting until
//   an item that would emit a result finds the result register full and stalled,
//   then byte_stall rises until the receiver takes the waiting result.
`include "multi_width_crc_engine_assert.svh"

module multi_width_crc_engine (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [2:0]                       cfg_index,
	input  logic [31:0]                      cfg_wdata,
	input  logic                             byte_valid,
	output logic                             byte_stall,
	input  mwce_pkg::byte_item_t             byte_item,
	output logic                             res_valid,
	input  logic                             res_stall,
	output mwce_pkg::res_item_t              res_item
);
	import mwce_pkg::*;

	logic        module_ready_q;
	logic [7:0]  poly_8_q;
	logic [15:0] poly_16_q;
	logic [31:0] poly_32_q;
	logic [7:0]  seed_8_q;
	logic [15:0] seed_16_q;
	logic [31:0] seed_32_q;
	logic [31:0] crc_q;

	byte_item_t  item_s1;
	logic        valid_s1;
	res_item_t   res_item_q;
	logic        res_valid_q;

	logic        emits_s1;
	logic        adv_s1;
	logic        upd_s1;
	logic [31:0] start_s1;
	logic [31:0] aligned_s1;
	logic [31:0] poly_al_s1;
	logic [31:0] stepped_s1;
	logic [31:0] crc_new_s1;
	logic [31:0] crc_out_s1;
	res_item_t   res_next;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			module_ready_q <= 1'b0;
			poly_8_q       <= POLY_8_RST;
			poly_16_q      <= POLY_16_RST;
			poly_32_q      <= POLY_32_RST;
			seed_8_q       <= SEED_8_RST;
			seed_16_q      <= SEED_16_RST;
			seed_32_q      <= SEED_32_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODULE_READY: module_ready_q <= cfg_wdata[0];
				REG_POLY_8:       poly_8_q       <= cfg_wdata[7:0];
				REG_POLY_16:      poly_16_q      <= cfg_wdata[15:0];
				REG_POLY_32:      poly_32_q      <= cfg_wdata;
				REG_SEED_8:       seed_8_q       <= cfg_wdata[7:0];
				REG_SEED_16:      seed_16_q      <= cfg_wdata[15:0];
				REG_SEED_32:      seed_32_q      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// handshake between the input stage and the result register
	assign emits_s1   = valid_s1 && item_s1.last_byte && (item_s1.cmd != CMD_NONE);
	assign adv_s1     = !emits_s1 || !res_valid_q || !res_stall;
	assign byte_stall = valid_s1 && !adv_s1;
	assign upd_s1     = valid_s1 && adv_s1 && module_ready_q && (item_s1.cmd != CMD_NONE);

	assign start_s1 = item_s1.first_byte ? item_s1.start_value : crc_q;

	// left-align register and polynomial so one 32-bit network serves every width
	always_comb begin
		case (item_s1.cmd)
			CMD_CRC8: begin
				aligned_s1 = {(item_s1.first_byte && item_s1.use_initial) ? seed_8_q
					: start_s1[7:0], 24'd0};
				poly_al_s1 = {poly_8_q, 24'd0};
			end
			CMD_CRC16: begin
				aligned_s1 = {(item_s1.first_byte && item_s1.use_initial) ? seed_16_q
					: start_s1[15:0], 16'd0};
				poly_al_s1 = {poly_16_q, 16'd0};
			end
			default: begin
				aligned_s1 = (item_s1.first_byte && item_s1.use_initial) ? seed_32_q
					: start_s1;
				poly_al_s1 = poly_32_q;
			end
		endcase
	end

	assign stepped_s1 = crc_byte_step(aligned_s1, item_s1.data_byte, poly_al_s1);

	always_comb begin
		case (item_s1.cmd)
			CMD_CRC8: begin
				crc_new_s1 = {24'd0, stepped_s1[31:24]};
				crc_out_s1 = {24'd0, stepped_s1[31:24] ^ XOROUT_8};
			end
			CMD_CRC16: begin
				crc_new_s1 = {16'd0, stepped_s1[31:16]};
				crc_out_s1 = {16'd0, stepped_s1[31:16] ^ XOROUT_16};
			end
			default: begin
				crc_new_s1 = stepped_s1;
				crc_out_s1 = stepped_s1 ^ XOROUT_32;
			end
		endcase
	end

	always_comb begin
		if (module_ready_q) begin
			res_next.crc_value = crc_out_s1;
			res_next.status    = STATUS_OK;
		end else begin
			res_next.crc_value = 32'd0;
			res_next.status    = STATUS_NOT_READY;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			item_s1 <= byte_item;
		end
	end

	// running crc, kept right-aligned at the width of its last update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= 32'd0;
		end else if (upd_s1) begin
			crc_q <= crc_new_s1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emits_s1 && adv_s1) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emits_s1 && adv_s1) begin
			res_item_q <= res_next;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

	`MWCE_ASSERT_SAME(a_stall_only_on_full_result, clk, arst_n,
		byte_stall, res_valid_q && res_stall)
	`MWCE_ASSERT_SAME(a_not_ready_result_zero, clk, arst_n,
		res_valid_q && res_item_q.status, res_item_q.crc_value == 32'd0)
	`MWCE_ASSERT_NEXT(a_crc_holds_without_update, clk, arst_n,
		!upd_s1, $stable(crc_q))
	`MWCE_ASSERT_NEXT(a_emit_fills_result, clk, arst_n,
		emits_s1 && adv_s1, res_valid_q)

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for multi_width_crc_engine
// runs directed and random byte streams against a behavioral crc predictor
// depends on mwce_pkg and the multi_width_crc_engine rtl
module tb_top;
	import mwce_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_wdata = '0;
	logic        byte_valid = 1'b0;
	logic        byte_stall;
	byte_item_t  byte_item = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	res_item_t   res_item;

	// predictor state and shadow copy of the registers
	logic        shadow_ready;
	logic [7:0]  shadow_poly8, shadow_seed8;
	logic [15:0] shadow_poly16, shadow_seed16;
	logic [31:0] shadow_poly32, shadow_seed32;
	logic [31:0] running_crc;

	res_item_t   pending_crcs[$];
	res_item_t   oldest_crc;
	int          fail_count = 0;
	int          snd_gap_pct = 0;
	int          rcv_stall_pct = 0;

	multi_width_crc_engine i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_item (byte_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		res_stall <= ($urandom_range(99) < rcv_stall_pct);
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch: %s: got %h, want %h", what, got, want);
		fail_count++;
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (pending_crcs.size() == 0) begin
				report_mismatch("result with nothing pending", res_item.crc_value, '0);
			end else begin
				oldest_crc = pending_crcs.pop_front();
				if (res_item.crc_value !== oldest_crc.crc_value)
					report_mismatch("crc_value", res_item.crc_value, oldest_crc.crc_value);
				if (res_item.status !== oldest_crc.status)
					report_mismatch("status", 32'(res_item.status), 32'(oldest_crc.status));
			end
		end
	end

	// advances the running crc by one accepted byte and queues any result
	task automatic advance_crc(input byte_item_t it);
		int          w;
		logic [31:0] poly, seed, xorout, mask, top, crc;
		res_item_t   res;
		if (it.cmd == CMD_NONE)
			return;
		if (!shadow_ready) begin
			if (it.last_byte) begin
				res.crc_value = '0;
				res.status = STATUS_NOT_READY;
				pending_crcs.push_back(res);
			end
			return;
		end
		case (it.cmd)
			CMD_CRC8: begin
				w = 8; poly = 32'(shadow_poly8); seed = 32'(shadow_seed8);
				xorout = 32'(XOROUT_8); mask = 32'h0000_00FF; top = 32'h0000_0080;
			end
			CMD_CRC16: begin
				w = 16; poly = 32'(shadow_poly16); seed = 32'(shadow_seed16);
				xorout = 32'(XOROUT_16); mask = 32'h0000_FFFF; top = 32'h0000_8000;
			end
			default: begin
				w = 32; poly = shadow_poly32; seed = shadow_seed32;
				xorout = XOROUT_32; mask = 32'hFFFF_FFFF; top = 32'h8000_0000;
			end
		endcase
		if (it.first_byte)
			crc = it.use_initial ? seed : it.start_value;
		else
			crc = running_crc;
		crc &= mask;
		crc ^= {24'd0, it.data_byte} << (w - 8);
		for (int b = 0; b < 8; b++) begin
			if (crc & top)
				crc = ((crc << 1) ^ poly) & mask;
			else
				crc = (crc << 1) & mask;
		end
		running_crc = crc;
		if (it.last_byte) begin
			res.crc_value = (crc ^ xorout) & mask;
			res.status = STATUS_OK;
			pending_crcs.push_back(res);
		end
	endtask

	// entered and left at a falling edge
	task automatic send_byte(input byte_item_t it);
		while ($urandom_range(99) < snd_gap_pct) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid <= 1'b1;
		byte_item <= it;
		do @(posedge clk); while (byte_stall);
		advance_crc(it);
		@(negedge clk);
	endtask

	function automatic byte_item_t make_byte(input logic [1:0] cmd, input logic [7:0] data,
			input logic first, input logic last, input logic use_init,
			input logic [31:0] start);
		byte_item_t it;
		it.cmd = cmd;
		it.data_byte = data;
		it.first_byte = first;
		it.last_byte = last;
		it.use_initial = use_init;
		it.start_value = start;
		return it;
	endfunction

	// idle the byte side and let every pending result and any byte in flight drain
	task automatic drain_results();
		byte_valid <= 1'b0;
		while (pending_crcs.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		case (idx)
			REG_MODULE_READY: shadow_ready = val[0];
			REG_POLY_8:       shadow_poly8 = val[7:0];
			REG_POLY_16:      shadow_poly16 = val[15:0];
			REG_POLY_32:      shadow_poly32 = val;
			REG_SEED_8:       shadow_seed8 = val[7:0];
			REG_SEED_16:      shadow_seed16 = val[15:0];
			REG_SEED_32:      shadow_seed32 = val;
			default: ;
		endcase
	endtask

	task automatic configure(input logic ready, input logic [31:0] p8, input logic [31:0] p16,
			input logic [31:0] p32, input logic [31:0] s8, input logic [31:0] s16,
			input logic [31:0] s32);
		write_reg(REG_MODULE_READY, {31'd0, ready});
		write_reg(REG_POLY_8, p8);
		write_reg(REG_POLY_16, p16);
		write_reg(REG_POLY_32, p32);
		write_reg(REG_SEED_8, s8);
		write_reg(REG_SEED_16, s16);
		write_reg(REG_SEED_32, s32);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// out of reset the engine is not initialised: every last item with a valid width select reports an error
	task automatic test_not_ready();
		send_byte(make_byte(CMD_CRC8, 8'h00, 1'b1, 1'b1, 1'b1, 32'h0));
		send_byte(make_byte(CMD_CRC32, 8'hFF, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF));
		send_byte(make_byte(CMD_CRC16, 8'h5A, 1'b0, 1'b1, 1'b0, 32'h1234_5678));
		send_byte(make_byte(CMD_NONE, 8'hA5, 1'b1, 1'b1, 1'b1, 32'h0));
		drain_results();
	endtask

	task automatic test_directed_calls();
		// continuation with the running crc register still clear from reset
		send_byte(make_byte(CMD_CRC16, 8'h31, 1'b0, 1'b1, 1'b0, 32'h0));
		// single-item calls at the data and start extremes
		send_byte(make_byte(CMD_CRC8, 8'h00, 1'b1, 1'b1, 1'b1, 32'h0));
		send_byte(make_byte(CMD_CRC8, 8'hFF, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF));
		send_byte(make_byte(CMD_CRC16, 8'h00, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF));
		send_byte(make_byte(CMD_CRC32, 8'hFF, 1'b1, 1'b1, 1'b0, 32'h0));
		send_byte(make_byte(CMD_CRC32, 8'h80, 1'b1, 1'b1, 1'b1, 32'h0));
		// two-item crc-16 call from the seed
		send_byte(make_byte(CMD_CRC16, 8'h31, 1'b1, 1'b0, 1'b1, 32'h0));
		send_byte(make_byte(CMD_CRC16, 8'h32, 1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF));
		// crc-32 call with an unused width select in the middle, marked last
		send_byte(make_byte(CMD_CRC32, 8'hFF, 1'b1, 1'b0, 1'b0, 32'h0));
		send_byte(make_byte(CMD_NONE, 8'h12, 1'b0, 1'b1, 1'b0, 32'h0));
		send_byte(make_byte(CMD_CRC32, 8'h00, 1'b0, 1'b0, 1'b1, 32'h0));
		send_byte(make_byte(CMD_CRC32, 8'h80, 1'b0, 1'b1, 1'b0, 32'h0));
		// width changes mid-call: a narrower width truncates the running value, a wider one zero-extends it
		send_byte(make_byte(CMD_CRC32, 8'hA5, 1'b1, 1'b0, 1'b0, 32'hDEAD_BEEF));
		send_byte(make_byte(CMD_CRC8, 8'h3C, 1'b0, 1'b1, 1'b0, 32'h0));
		send_byte(make_byte(CMD_CRC16, 8'h7E, 1'b1, 1'b0, 1'b0, 32'hFFFF_0F0F));
		send_byte(make_byte(CMD_CRC32, 8'hC3, 1'b0, 1'b1, 1'b1, 32'h0));
		// continuation after a finished call
		send_byte(make_byte(CMD_CRC32, 8'h01, 1'b0, 1'b1, 1'b0, 32'h0));
		drain_results();
	endtask

	// mostly well-formed calls with random content, some noise items
	task automatic send_random_call(inout int sent);
		byte_item_t  it;
		int          len;
		logic [1:0]  cmd;
		if ($urandom_range(9) == 0) begin
			it = make_byte(2'($urandom_range(3)), 8'($urandom), 1'($urandom),
				1'($urandom), 1'($urandom), $urandom);
			send_byte(it);
			if (it.cmd != CMD_NONE)
				sent++;
		end else begin
			len = $urandom_range(1, 6);
			cmd = 2'($urandom_range(2));
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(19) == 0)
					cmd = 2'($urandom_range(2));
				it = make_byte(cmd, 8'($urandom), (i == 0), (i == len - 1),
					1'($urandom), $urandom);
				send_byte(it);
				sent++;
			end
		end
	endtask

	task automatic test_random_calls();
		int sent;
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin snd_gap_pct = 11; rcv_stall_pct = 85; end
				1: begin snd_gap_pct = 85; rcv_stall_pct = 11; end
				default: begin snd_gap_pct = 0; rcv_stall_pct = 0; end
			endcase
			for (int phase = 0; phase < 4; phase++) begin
				case (phase)
					0: configure(1'b1, 32'(POLY_8_RST), 32'(POLY_16_RST), POLY_32_RST,
						32'(SEED_8_RST), 32'(SEED_16_RST), SEED_32_RST);
					1: configure(1'b1, '0, '0, '0, '0, '0, '0);
					2: configure(1'b1, 32'hFF, 32'hFFFF, 32'hFFFF_FFFF,
						32'hFF, 32'hFFFF, 32'hFFFF_FFFF);
					default: configure(($urandom_range(3) != 0), $urandom, $urandom,
						$urandom, $urandom, $urandom, $urandom);
				endcase
				sent = 0;
				while (sent < 130)
					send_random_call(sent);
				drain_results();
			end
		end
	endtask

	initial begin
		shadow_ready = 1'b0;
		shadow_poly8 = POLY_8_RST;
		shadow_poly16 = POLY_16_RST;
		shadow_poly32 = POLY_32_RST;
		shadow_seed8 = SEED_8_RST;
		shadow_seed16 = SEED_16_RST;
		shadow_seed32 = SEED_32_RST;
		running_crc = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		snd_gap_pct = 11;
		rcv_stall_pct = 85;
		test_not_ready();
		configure(1'b1, 32'(POLY_8_RST), 32'(POLY_16_RST), POLY_32_RST,
			32'(SEED_8_RST), 32'(SEED_16_RST), SEED_32_RST);
		test_directed_calls();
		test_random_calls();

		repeat (10) @(posedge clk);
		if (pending_crcs.size() != 0)
			report_mismatch("results never arrived", '0, 32'(pending_crcs.size()));
		if (fail_count == 0) begin
			$display("** multi_width_crc_engine: PASSED **");
		end else begin
			$display("** multi_width_crc_engine: FAILED **");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout waiting for the engine");
		$display("** multi_width_crc_engine: FAILED **");
		$finish;
	end

endmodule

// ----- multi_width_crc_engine.f -----
+incdir+rtl
rtl/mwce_pkg.sv
rtl/multi_width_crc_engine.sv
tb/tb_top.sv
